// File: sv/rc5tx_pkg.sv
// Shared types and constants for the RC5 infrared Manchester transmitter.
package rc5tx_pkg;

  localparam int unsigned FRAME_HALF_BITS = 28;
  localparam int unsigned FRAME_BITS      = 14;
  localparam int unsigned PAYLOAD_W       = 11;
  localparam int unsigned TICKS_W         = 16;
  localparam int unsigned HB_CNT_W        = $clog2(FRAME_HALF_BITS + 1);
  localparam int unsigned IN_TDATA_W      = 16;
  localparam int unsigned OUT_TDATA_W     = 8;

  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_START = 1'b1;
  localparam logic [1:0] START_BITS = 2'b11;

  typedef logic [TICKS_W-1:0]   ticks_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic carrier_on;
  } rc5tx_res_t;

  localparam int unsigned RES_W = $bits(rc5tx_res_t);

endpackage

// File: sv/rc5_ir_manchester_transmitter.sv
// RC5 infrared Manchester transmitter top level: stream ports, config register, output buffer.
// Takes one beat per clock while in_tready is high. A start beat (in_tuser = 1) loads a 14-bit
// frame of two start ones, the toggle bit and the 11 payload bits, sent LSB first as 28 Manchester
// half-bits; a tick beat (in_tuser = 0) advances the current half-bit, lasting cfg_half_bit_ticks
// ticks (0 acts as 1). Every accepted beat yields one result beat with the carrier gate, busy flag
// and frame-done flag after that beat's update, registered into the two-entry output buffer, which
// lets in_tready stay high while one result waits; a stalled output backs up only after two beats.
module rc5_ir_manchester_transmitter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rc5tx_pkg::IN_TDATA_W-1:0]     in_tdata,  // [10:0] payload, rest zero
  input  logic                                 in_tuser,  // [0] req_type
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rc5tx_pkg::OUT_TDATA_W-1:0]    out_tdata, // [0] carrier_on [1] busy_res
                                                          // [2] frame_done, rest zero
  input  logic                                 cfg_wr_en,
  input  logic [rc5tx_pkg::TICKS_W-1:0]        cfg_wr_data
);
  import rc5tx_pkg::*;

  ticks_t     half_bit_ticks_r;
  rc5tx_res_t res;
  rc5tx_res_t out_data_r,  out_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  rc5tx_res_t skid_data_r, skid_data_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic       acc;
  logic       take;

  assign in_tready = ~skid_valid_r;
  assign acc       = in_tvalid & in_tready;
  assign take      = out_valid_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_ticks_r <= ticks_t'(89);
    end else if (cfg_wr_en) begin
      half_bit_ticks_r <= cfg_wr_data;
    end
  end

  rc5tx_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .req_type       (in_tuser),
    .payload        (in_tdata[PAYLOAD_W-1:0]),
    .half_bit_ticks (half_bit_ticks_r),
    .res            (res)
  );

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = acc;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = acc;
        out_data_nxt  = res;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = acc;
      out_data_nxt  = res;
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_data_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output stage");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("beat accepted under stall was not buffered");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !skid_valid_r && !acc) |=> !out_valid_r)
    else $error("output stage still valid after last beat taken");

endmodule

// File: sv/rc5tx_core.sv
// Frame state and Manchester half-bit sequencing, one beat per cycle.
module rc5tx_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                req_type,
  input  rc5tx_pkg::payload_t payload,
  input  rc5tx_pkg::ticks_t   half_bit_ticks,
  output rc5tx_pkg::rc5tx_res_t res
);
  import rc5tx_pkg::*;

  logic [FRAME_BITS-1:0] frame_shift_r,    frame_shift_nxt;
  logic [HB_CNT_W-1:0]   half_bits_sent_r, half_bits_sent_nxt;
  logic                  in_first_half_r,  in_first_half_nxt;
  ticks_t                tick_count_r,     tick_count_nxt;
  logic                  toggle_bit_r,     toggle_bit_nxt;
  logic                  carrier_r,        carrier_nxt;
  logic                  sending_r,        sending_nxt;
  logic                  done;

  ticks_t                limit;
  ticks_t                tick_inc;
  logic [FRAME_BITS-1:0] start_frame;

  assign limit       = (half_bit_ticks == '0) ? ticks_t'(1) : half_bit_ticks;
  assign tick_inc    = tick_count_r + ticks_t'(1);
  assign start_frame = {payload, ~toggle_bit_r, START_BITS};

  always_comb begin
    frame_shift_nxt    = frame_shift_r;
    half_bits_sent_nxt = half_bits_sent_r;
    in_first_half_nxt  = in_first_half_r;
    tick_count_nxt     = tick_count_r;
    toggle_bit_nxt     = toggle_bit_r;
    carrier_nxt        = carrier_r;
    sending_nxt        = sending_r;
    done               = 1'b0;
    if (acc) begin
      if (req_type == REQ_START) begin
        // first half of bit 0 starts at once
        toggle_bit_nxt     = ~toggle_bit_r;
        frame_shift_nxt    = start_frame;
        half_bits_sent_nxt = HB_CNT_W'(1);
        in_first_half_nxt  = 1'b1;
        carrier_nxt        = ~start_frame[0];
        tick_count_nxt     = '0;
        sending_nxt        = 1'b1;
      end else if (sending_r) begin
        if (tick_inc >= limit) begin
          tick_count_nxt = '0;
          if (half_bits_sent_r < HB_CNT_W'(FRAME_HALF_BITS)) begin
            in_first_half_nxt  = ~in_first_half_r;
            half_bits_sent_nxt = half_bits_sent_r + HB_CNT_W'(1);
            if (!in_first_half_r) begin
              carrier_nxt = ~frame_shift_r[0];
            end else begin
              carrier_nxt     = frame_shift_r[0];
              frame_shift_nxt = {1'b0, frame_shift_r[FRAME_BITS-1:1]};
            end
          end else begin
            in_first_half_nxt = 1'b0;
            carrier_nxt       = 1'b0;
            sending_nxt       = 1'b0;
            done              = 1'b1;
          end
        end else begin
          tick_count_nxt = tick_inc;
        end
      end
    end
  end

  assign res.carrier_on = carrier_nxt;
  assign res.busy_res   = sending_nxt;
  assign res.frame_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r    <= '0;
      half_bits_sent_r <= '0;
      in_first_half_r  <= 1'b0;
      tick_count_r     <= '0;
      toggle_bit_r     <= 1'b0;
      carrier_r        <= 1'b0;
      sending_r        <= 1'b0;
    end else begin
      frame_shift_r    <= frame_shift_nxt;
      half_bits_sent_r <= half_bits_sent_nxt;
      in_first_half_r  <= in_first_half_nxt;
      tick_count_r     <= tick_count_nxt;
      toggle_bit_r     <= toggle_bit_nxt;
      carrier_r        <= carrier_nxt;
      sending_r        <= sending_nxt;
    end
  end

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (!carrier_r && !in_first_half_r))
    else $error("carrier or half-bit phase set while idle");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (half_bits_sent_r != '0))
    else $error("sending with no half-bit started");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && req_type == REQ_START) |=>
      (sending_r && in_first_half_r && half_bits_sent_r == HB_CNT_W'(1)
       && tick_count_r == '0 && toggle_bit_r != $past(toggle_bit_r)))
    else $error("frame start did not load first half-bit");

endmodule
